// ===== sv/fse_pkg.sv =====
// Shared types and codes for the start/end delimited frame extractor.
package fse_pkg;

    // Widths of the fixed payload fields and of the configuration index and max length
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_LEN_W  = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd3;

    // Input command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [LEN_W-1:0] COUNT_MAX = 16'hFFFF;

    // Per-frame fields repeated on every output beat
    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic [TIME_W-1:0] start_time;
        logic              truncated;
    } frame_meta_t;

    // One output beat
    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last;
        frame_meta_t       meta;
    } out_beat_t;

endpackage

// ===== sv/fse_front.sv =====
// Front end: configuration registers, byte classification and frame bookkeeping.
module fse_front #(
    parameter int FRAME_DEPTH = 64,
    parameter int IW = 6,
    parameter int KW = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fse_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_command,
    input  logic [fse_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic [fse_pkg::TIME_W-1:0]    s_time_stamp,
    input  logic                          q_full,
    output logic                          push,
    output fse_pkg::frame_meta_t          push_meta,
    output logic [KW-1:0]                 push_kept,
    output logic                          push_bank,
    output logic                          wr_en,
    output logic [IW:0]                   wr_addr,
    output logic [fse_pkg::BYTE_W-1:0]    wr_data
);
    import fse_pkg::*;

    localparam int LW = (KW > MAX_LEN_W) ? KW : MAX_LEN_W;

    logic                 rx_enable_reg;
    logic [BYTE_W-1:0]    start_byte_reg;
    logic [BYTE_W-1:0]    end_byte_reg;
    logic [MAX_LEN_W-1:0] max_length_reg;

    logic              in_frame_reg, in_frame_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [KW-1:0]     kept_reg, kept_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic              bank_reg, bank_next;

    logic              accept;
    logic              is_start;
    logic              is_end;
    logic [LW-1:0]     ml_ext;
    logic [KW-1:0]     limit;
    logic [LEN_W-1:0]  c_count;
    logic [KW-1:0]     c_kept;
    logic [TIME_W-1:0] c_time;

    // Stall while both store banks hold frames awaiting readout
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_start = (s_data_byte == start_byte_reg);
    assign is_end   = (s_data_byte == end_byte_reg);

    // Clamp the keep limit to 1 .. FRAME_DEPTH
    always_comb
    begin
        ml_ext = LW'(max_length_reg);
        if (ml_ext == '0)
        begin
            limit = KW'(1);
        end
        else if (ml_ext > LW'(FRAME_DEPTH))
        begin
            limit = KW'(FRAME_DEPTH);
        end
        else
        begin
            limit = KW'(ml_ext);
        end
    end

    // Classify the beat and work out the next frame state
    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        kept_next     = kept_reg;
        time_next     = time_reg;
        bank_next     = bank_reg;
        c_count       = count_reg;
        c_kept        = kept_reg;
        c_time        = time_reg;
        wr_en         = 1'b0;
        wr_addr       = {bank_reg, {IW{1'b0}}};
        wr_data       = s_data_byte;
        push          = 1'b0;
        if (accept)
        begin
            if (s_command == CMD_CLEAR)
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
                kept_next     = '0;
            end
            else if (rx_enable_reg)
            begin
                if (!in_frame_reg)
                begin
                    if (is_start)
                    begin
                        in_frame_next = 1'b1;
                        count_next    = LEN_W'(1);
                        kept_next     = KW'(1);
                        time_next     = s_time_stamp;
                        wr_en         = 1'b1;
                    end
                end
                else
                begin
                    if (is_start)
                    begin
                        c_count = LEN_W'(1);
                        c_kept  = KW'(1);
                        c_time  = s_time_stamp;
                        wr_en   = 1'b1;
                    end
                    else
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            c_count = count_reg + LEN_W'(1);
                        end
                        if (kept_reg < limit)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = {bank_reg, kept_reg[IW-1:0]};
                            c_kept  = kept_reg + KW'(1);
                        end
                    end
                    if (is_end)
                    begin
                        // Hand the finished frame to the back end and swap banks
                        push          = 1'b1;
                        in_frame_next = 1'b0;
                        count_next    = '0;
                        kept_next     = '0;
                        time_next     = c_time;
                        bank_next     = !bank_reg;
                    end
                    else
                    begin
                        count_next = c_count;
                        kept_next  = c_kept;
                        time_next  = c_time;
                    end
                end
            end
        end
    end

    assign push_meta.frame_length = c_count;
    assign push_meta.start_time   = c_time;
    assign push_meta.truncated    = (c_count != LEN_W'(c_kept));
    assign push_kept              = c_kept;
    assign push_bank              = bank_reg;

    // Hold configuration and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_enable_reg  <= 1'b0;
            start_byte_reg <= '0;
            end_byte_reg   <= '0;
            max_length_reg <= MAX_LEN_W'(64);
            in_frame_reg   <= 1'b0;
            count_reg      <= '0;
            kept_reg       <= '0;
            time_reg       <= '0;
            bank_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RX_ENABLE:  rx_enable_reg  <= cfg_data[0];
                    CFG_START_BYTE: start_byte_reg <= cfg_data;
                    CFG_END_BYTE:   end_byte_reg   <= cfg_data;
                    CFG_MAX_LENGTH: max_length_reg <= cfg_data[MAX_LEN_W-1:0];
                    default:        rx_enable_reg  <= rx_enable_reg;
                endcase
            end
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            kept_reg     <= kept_next;
            time_reg     <= time_next;
            bank_reg     <= bank_next;
        end
    end

endmodule

// ===== sv/fse_desc_queue.sv =====
// Two-entry queue of completed frame descriptors between front and back.
module fse_desc_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         head_valid,
    output logic [W-1:0] head
);
    logic [W-1:0] q_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    // Store descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/fse_back.sv =====
// Back end: double-banked frame store, readout sequencer and output skid buffer.
module fse_back #(
    parameter int FRAME_DEPTH = 64,
    parameter int IW = 6,
    parameter int KW = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [IW:0]                wr_addr,
    input  logic [fse_pkg::BYTE_W-1:0] wr_data,
    input  logic                       head_valid,
    input  fse_pkg::frame_meta_t       head_meta,
    input  logic [KW-1:0]              head_kept,
    input  logic                       head_bank,
    output logic                       pop,
    output logic                       ob_valid,
    input  logic                       ob_ready,
    output fse_pkg::out_beat_t         ob_beat
);
    import fse_pkg::*;

    localparam int AW = IW + 1;

    logic [BYTE_W-1:0] mem [2**AW];
    logic [BYTE_W-1:0] rd_data_reg;
    frame_meta_t       pend_meta_reg;
    logic              pend_last_reg;
    logic              inflight_reg;
    logic [IW-1:0]     rd_idx_reg;

    out_beat_t         ob_reg [2];
    logic              ob_wr_ptr_reg;
    logic              ob_rd_ptr_reg;
    logic [1:0]        ob_cnt_reg;

    logic rd_en;
    logic rd_last;
    logic ob_pop;
    logic room;

    assign ob_pop  = ob_valid && ob_ready;
    // Issue a read only when its byte is sure of a place in the skid buffer
    assign room    = ({1'b0, ob_cnt_reg} + {2'b0, inflight_reg}) < (3'd2 + {2'b0, ob_pop});
    assign rd_en   = head_valid && room;
    assign rd_last = ((KW'(rd_idx_reg) + KW'(1)) == head_kept);
    assign pop     = rd_en && rd_last;

    // Frame store: front writes one bank while the other is read out
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{head_bank, rd_idx_reg}];
        end
    end

    // Carry the frame fields alongside the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pend_meta_reg <= head_meta;
            pend_last_reg <= rd_last;
        end
        if (inflight_reg)
        begin
            ob_reg[ob_wr_ptr_reg] <= '{frame_byte: rd_data_reg,
                                       last:       pend_last_reg,
                                       meta:       pend_meta_reg};
        end
    end

    // Advance the readout index and the skid buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            inflight_reg  <= 1'b0;
            ob_wr_ptr_reg <= 1'b0;
            ob_rd_ptr_reg <= 1'b0;
            ob_cnt_reg    <= 2'd0;
        end
        else
        begin
            inflight_reg <= rd_en;
            if (rd_en)
            begin
                rd_idx_reg <= rd_last ? '0 : rd_idx_reg + IW'(1);
            end
            if (inflight_reg)
            begin
                ob_wr_ptr_reg <= !ob_wr_ptr_reg;
            end
            if (ob_pop)
            begin
                ob_rd_ptr_reg <= !ob_rd_ptr_reg;
            end
            ob_cnt_reg <= ob_cnt_reg + {1'b0, inflight_reg} - {1'b0, ob_pop};
        end
    end

    assign ob_valid = (ob_cnt_reg != 2'd0);
    assign ob_beat  = ob_reg[ob_rd_ptr_reg];

endmodule

// ===== sv/start_end_delimited_frame_extractor.sv =====
// Top level of the start/end delimited frame extractor.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  s       | in        | s_tvalid/s_tready  | s_tdata (byte, time), s_tuser (command)
//  m       | out       | m_tvalid/m_tready  | m_tdata, m_tuser (truncated), m_tlast
//
// The front takes one input beat per cycle while fewer than two completed
// frames wait in the store; with two waiting, s_tready stays low until the
// older frame's last byte has been read from its bank.
// The back sends one byte per cycle while m_tready is high. Once the end byte
// is taken, the frame's descriptor is registered in the queue; each byte then
// passes the store read register and the skid register. Reset clears all
// control state at once; the store needs no clearing pass. m_tready low
// stalls the back at once and reaches the front only once two frames wait.
module start_end_delimited_frame_extractor #(
    parameter int FRAME_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fse_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // data_byte[7:0], time_stamp[39:8]
    input  logic                          s_tuser,  // command[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata,  // frame_byte[7:0], frame_length[23:8],
                                                    // start_time[55:24]
    output logic                          m_tuser,  // truncated[0]
    output logic                          m_tlast
);
    import fse_pkg::*;

    localparam int IW = $clog2(FRAME_DEPTH);
    localparam int KW = $clog2(FRAME_DEPTH + 1);
    localparam int DW = $bits(frame_meta_t) + KW + 1;

    logic              q_full;
    logic              push;
    frame_meta_t       push_meta;
    logic [KW-1:0]     push_kept;
    logic              push_bank;
    logic              wr_en;
    logic [IW:0]       wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              pop;
    logic              head_valid;
    logic [DW-1:0]     head;
    frame_meta_t       head_meta;
    logic [KW-1:0]     head_kept;
    logic              head_bank;
    out_beat_t         ob_beat;

    fse_front #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .IW          (IW),
        .KW          (KW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_command    (s_tuser),
        .s_data_byte  (s_tdata[7:0]),
        .s_time_stamp (s_tdata[39:8]),
        .q_full       (q_full),
        .push         (push),
        .push_meta    (push_meta),
        .push_kept    (push_kept),
        .push_bank    (push_bank),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    fse_desc_queue #(
        .W (DW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_meta, push_kept, push_bank}),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Unpack the head descriptor
    assign {head_meta, head_kept, head_bank} = head;

    fse_back #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .IW          (IW),
        .KW          (KW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .head_valid (head_valid),
        .head_meta  (head_meta),
        .head_kept  (head_kept),
        .head_bank  (head_bank),
        .pop        (pop),
        .ob_valid   (m_tvalid),
        .ob_ready   (m_tready),
        .ob_beat    (ob_beat)
    );

    // Pack the output beat
    assign m_tdata = {ob_beat.meta.start_time, ob_beat.meta.frame_length, ob_beat.frame_byte};
    assign m_tuser = ob_beat.meta.truncated;
    assign m_tlast = ob_beat.last;

endmodule

// ===== sv/fse_checker.sv =====
// Port-level checks for the frame extractor, bound to the top level.
module fse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // No output beat is offered after an edge that samples reset asserted
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("m_tvalid high during reset");

    // A stalled output beat holds its data and last flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

    // Beats of one frame carry the same length and start time
    a_meta_same: assert property (@(posedge clk) disable iff (!rst_n)
        ((m_tvalid && m_tready && !m_tlast) ##1 m_tvalid)
        |-> (m_tdata[55:8] == $past(m_tdata[55:8])))
        else $error("frame fields changed within a frame");

    // A frame of length one is a single untruncated beat
    a_len_one: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[23:8] == 16'd1)) |-> (m_tlast && !m_tuser))
        else $error("frame of length one not a single beat");

endmodule

bind start_end_delimited_frame_extractor fse_checker u_fse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
